FILE: hw/rtl/pnp_pkg.sv
// Shared types, status codes and character helpers for the pitch name parser.
package pnp_pkg;

    // One byte of pitch text
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_t;

    // One parse result
    typedef struct packed {
        logic [6:0] midi_pitch;
        logic [2:0] status;
    } out_t;

    // Status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_EMPTY        = 3'd1;
    localparam logic [2:0] ST_BAD_LETTER   = 3'd2;
    localparam logic [2:0] ST_NO_OCTAVE    = 3'd3;
    localparam logic [2:0] ST_BAD_OCTAVE   = 3'd4;
    localparam logic [2:0] ST_OCTAVE_RANGE = 3'd5;
    localparam logic [2:0] ST_TRAILING     = 3'd6;
    localparam logic [2:0] ST_NOTE_RANGE   = 3'd7;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // {valid, pitch class} for a note letter in either case
    function automatic logic [4:0] letter_decode(input logic [7:0] c);
        logic [7:0] lc;
        logic       ok;
        lc = c | 8'h20;
        ok = (c >= 8'h41 && c <= 8'h47) || (c >= 8'h61 && c <= 8'h67);
        if (!ok)
            return 5'd0;
        case (lc)
            8'h61:   return {1'b1, 4'd9};   // a
            8'h62:   return {1'b1, 4'd11};  // b
            8'h63:   return {1'b1, 4'd0};   // c
            8'h64:   return {1'b1, 4'd2};   // d
            8'h65:   return {1'b1, 4'd4};   // e
            8'h66:   return {1'b1, 4'd5};   // f
            8'h67:   return {1'b1, 4'd7};   // g
            default: return 5'd0;
        endcase
    endfunction

endpackage

FILE: hw/rtl/pnp_core.sv
// Parse state machine and octave accumulator; yields the result on the last byte.
module pnp_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  pnp_pkg::in_t  in_item,
    output logic          res_valid,
    output pnp_pkg::out_t res_data
);
    import pnp_pkg::*;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_LETTER = 3'd1;
    localparam logic [2:0] PH_SHARP  = 3'd2;
    localparam logic [2:0] PH_SIGN   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_TRAIL  = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    localparam logic [35:0] MAG_LIMIT = 36'd2147483648;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  pc_reg, pc_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic        ovf_reg, ovf_next;
    logic [2:0]  err_reg, err_next;

    // State after this byte, before end-of-text handling
    logic [2:0]  ph;
    logic [3:0]  pc;
    logic        ng;
    logic [31:0] mg;
    logic        ov;
    logic [2:0]  er;

    logic [7:0]  c;
    logic [4:0]  letter;
    logic [35:0] dig_sum;
    logic        dig_big;
    logic [31:0] dig_mag;
    logic [2:0]  close_reg_code;
    logic [2:0]  close_fin_code;
    logic [2:0]  fin_ph;
    logic [2:0]  fin_err;
    logic [3:0]  oct1;
    logic [7:0]  pitch_sum;
    logic [6:0]  fin_pitch;

    // End of the digit run: overflow, then range check
    function automatic logic [2:0] close_code(input logic neg, input logic ovf,
                                              input logic [31:0] mag);
        if (ovf || (!neg && mag[31]))
            return ST_BAD_OCTAVE;
        if (neg ? (mag > 32'd1) : (mag > 32'd9))
            return ST_OCTAVE_RANGE;
        return ST_OK;
    endfunction

    assign c      = in_item.char_code;
    assign letter = letter_decode(c);

    // Decimal accumulate: mag * 10 + digit, overflow sticks
    assign dig_sum = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {32'd0, c[3:0]};
    assign dig_big = ovf_reg || (dig_sum > MAG_LIMIT);
    assign dig_mag = dig_big ? mag_reg : dig_sum[31:0];

    assign close_reg_code = close_code(neg_reg, ovf_reg, mag_reg);

    // Per-byte phase machine
    always_comb
    begin
        ph = phase_reg;
        pc = pc_reg;
        ng = neg_reg;
        mg = mag_reg;
        ov = ovf_reg;
        er = err_reg;
        unique case (phase_reg) inside
            PH_LEAD:
            begin
                if (!is_ws(c))
                begin
                    if (letter[4])
                    begin
                        pc = letter[3:0];
                        ph = PH_LETTER;
                    end
                    else
                    begin
                        er = ST_BAD_LETTER;
                        ph = PH_ERROR;
                    end
                end
            end
            PH_LETTER, PH_SHARP:
            begin
                if (c == CH_HASH && phase_reg == PH_LETTER)
                begin
                    pc = pc_reg + 4'd1;
                    ph = PH_SHARP;
                end
                else if (is_ws(c))
                begin
                    er = ST_NO_OCTAVE;
                    ph = PH_ERROR;
                end
                else if (c == CH_MINUS)
                begin
                    ng = 1'b1;
                    ph = PH_SIGN;
                end
                else if (is_digit(c))
                begin
                    mg = dig_mag;
                    ov = dig_big;
                    ph = PH_DIGITS;
                end
                else
                begin
                    er = ST_BAD_OCTAVE;
                    ph = PH_ERROR;
                end
            end
            PH_SIGN:
            begin
                if (is_digit(c))
                begin
                    mg = dig_mag;
                    ov = dig_big;
                    ph = PH_DIGITS;
                end
                else
                begin
                    er = ST_BAD_OCTAVE;
                    ph = PH_ERROR;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit(c))
                begin
                    mg = dig_mag;
                    ov = dig_big;
                end
                else if (close_reg_code != ST_OK)
                begin
                    er = close_reg_code;
                    ph = PH_ERROR;
                end
                else if (!is_ws(c))
                begin
                    er = ST_TRAILING;
                    ph = PH_ERROR;
                end
                else
                begin
                    ph = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                if (!is_ws(c))
                begin
                    er = ST_TRAILING;
                    ph = PH_ERROR;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign close_fin_code = close_code(ng, ov, mg);

    // End-of-text: close the open phase and form the pitch
    always_comb
    begin
        fin_ph    = ph;
        fin_err   = er;
        fin_pitch = 7'd0;
        case (ph) inside
            PH_LEAD:
            begin
                fin_err = ST_EMPTY;
                fin_ph  = PH_ERROR;
            end
            PH_LETTER, PH_SHARP:
            begin
                fin_err = ST_NO_OCTAVE;
                fin_ph  = PH_ERROR;
            end
            PH_SIGN:
            begin
                fin_err = ST_BAD_OCTAVE;
                fin_ph  = PH_ERROR;
            end
            PH_DIGITS:
            begin
                if (close_fin_code != ST_OK)
                begin
                    fin_err = close_fin_code;
                    fin_ph  = PH_ERROR;
                end
                else
                begin
                    fin_ph = PH_TRAIL;
                end
            end
            default:
            begin
            end
        endcase
        // octave is -1..9 here, so octave + 1 fits in four bits
        oct1      = ng ? (4'd1 - mg[3:0]) : (mg[3:0] + 4'd1);
        pitch_sum = {4'd0, pc} + {1'b0, oct1, 3'b000} + {2'b00, oct1, 2'b00};
        if (fin_ph == PH_TRAIL)
        begin
            if (pitch_sum > 8'd127)
                fin_err = ST_NOTE_RANGE;
            else
                fin_pitch = pitch_sum[6:0];
        end
    end

    assign res_valid           = accept && in_item.end_of_text;
    assign res_data.midi_pitch = fin_pitch;
    assign res_data.status     = fin_err;

    // Next state: back to the start after the last byte
    always_comb
    begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        if (accept)
        begin
            if (in_item.end_of_text)
            begin
                phase_next = PH_LEAD;
                pc_next    = 4'd0;
                neg_next   = 1'b0;
                mag_next   = 32'd0;
                ovf_next   = 1'b0;
                err_next   = ST_OK;
            end
            else
            begin
                phase_next = ph;
                pc_next    = pc;
                neg_next   = ng;
                mag_next   = mg;
                ovf_next   = ov;
                err_next   = er;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            pc_reg    <= 4'd0;
            neg_reg   <= 1'b0;
            mag_reg   <= 32'd0;
            ovf_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            ovf_reg   <= ovf_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: hw/rtl/pitch_name_text_parser.sv
// A result is registered into the output register, or into the skid stage while a
// held result stalls there. Throughput: one byte per cycle unless in_stall is high;
// the parse state and octave accumulator update on each accepted byte, and input
// stalls only once a second result waits in the skid stage.
// Reset: asynchronous, active low; clears the parse state and empties both
// output stages.
module pitch_name_text_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  pnp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output pnp_pkg::out_t out_data
);
    import pnp_pkg::*;

    logic accept;
    logic res_valid;
    out_t res_data;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;
    logic skid_valid_reg, skid_valid_next;
    out_t skid_data_reg, skid_data_next;
    logic out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;

    pnp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_item  (in_data),
        .res_valid(res_valid),
        .res_data (res_data)
    );

    // Output register with skid stage
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_data;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hw/rtl/pnp_checker.sv
// Port-level checks for the pitch name parser, bound to the top level.
module pnp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input pnp_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_stall,
    input pnp_pkg::out_t out_data
);
    import pnp_pkg::*;

    // A held result keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Failed parses report pitch zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.midi_pitch == 7'd0)
        else $error("nonzero pitch with error status");

    // A fresh result follows a transfer of a last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.end_of_text))
        else $error("result without end of text");

    // Input stalls only once a result is held downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without held result");

endmodule

bind pitch_name_text_parser pnp_checker u_pnp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
